@@ design/depq_pkg.sv @@
// Shared types and codes for the double-ended priority queue.
`default_nettype none
package depq_pkg;
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REM_HI = 2'd1,
        KIND_REM_LO = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_WRITE,
        ST_OUT
    } state_t;

    localparam int unsigned ENTRY_W = 64;
endpackage
`default_nettype wire

@@ design/depq_ram.sv @@
// Generic single-port-write, one-read synchronous RAM with registered read.
`default_nettype none
module depq_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ design/double_ended_priority_queue.sv @@
// Double-ended priority queue over a circular buffer in one RAM.
// Remove-high/low read the chosen end in ST_RD, then ST_OUT; an empty remove, a full
// insert and a nop go straight to ST_OUT. Insert: ST_WRITE into an empty queue, else ST_RD
// and ST_CMP shift one entry up per pass, then ST_WRITE; the shift sets the insert rate.
// One word in flight; the next word is accepted the cycle after the result is taken.
// Reset clears occupancy and pointers; the RAM content is not cleared.
`default_nettype none
module double_ended_priority_queue #(
    parameter int unsigned CAPACITY = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic signed [31:0] priority_req,
    input  wire logic signed [31:0] payload,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] removed_payload,
    output logic [1:0]       status
);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    depq_pkg::state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;          // physical index of lowest
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    kind_reg, kind_next;
    logic [31:0]   prio_reg, prio_next, pay_reg, pay_next;
    logic [CW-1:0] pos_reg, pos_next;            // logical hole position
    logic [31:0]   res_reg, res_next;
    logic [1:0]    stat_reg, stat_next;
    logic          ov_reg, ov_next;

    logic                            we;
    logic [AW-1:0]                   waddr, raddr;
    logic [depq_pkg::ENTRY_W-1:0]    wdata, rdata;

    // logical to physical index, wraps at CAPACITY
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
        logic [CW:0] s;
        s = {1'b0, CW'(h)} + {1'b0, l};
        if (s >= {1'b0, CAP_C})
        begin
            s = s - {1'b0, CAP_C};
        end
        return s[AW-1:0];
    endfunction

    depq_ram #(.WIDTH(depq_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_ready        = (state_reg == depq_pkg::ST_IDLE) && !ov_reg;
    assign out_valid       = ov_reg;
    assign removed_payload = res_reg;
    assign status          = stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= depq_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        prio_reg <= prio_next;
        pay_reg  <= pay_next;
        pos_reg  <= pos_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
    end

    // sequencer: remove reads an end; insert shifts upward from the top
    always_comb
    begin
        logic hole_lt;
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        prio_next  = prio_reg;
        pay_next   = pay_reg;
        pos_next   = pos_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        ov_next    = ov_reg && !out_ready;
        we         = 1'b0;
        waddr      = phys(head_reg, pos_reg);
        wdata      = {prio_reg, pay_reg};
        raddr      = phys(head_reg, pos_reg - CW'(1));
        hole_lt    = ($signed(rdata[63:32]) > $signed(prio_reg));
        unique case (state_reg)
            depq_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    kind_next = kind;
                    prio_next = priority_req;
                    pay_next  = payload;
                    pos_next  = count_reg;
                    res_next  = '0;
                    stat_next = depq_pkg::STAT_OK;
                    state_next = depq_pkg::ST_OUT;
                    case (kind)
                        depq_pkg::KIND_INSERT:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                stat_next = depq_pkg::STAT_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = depq_pkg::ST_WRITE;
                            end
                            else
                            begin
                                raddr = phys(head_reg, count_reg - CW'(1));
                                state_next = depq_pkg::ST_RD;
                            end
                        end
                        depq_pkg::KIND_REM_HI, depq_pkg::KIND_REM_LO:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = depq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                raddr = (kind == depq_pkg::KIND_REM_HI)
                                      ? phys(head_reg, count_reg - CW'(1)) : head_reg;
                                state_next = depq_pkg::ST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            depq_pkg::ST_RD:
            begin
                // rdata holds the entry below the hole (or the removed end)
                if (kind_reg == depq_pkg::KIND_INSERT)
                begin
                    if (hole_lt)
                    begin
                        we    = 1'b1;
                        wdata = rdata;
                        pos_next = pos_reg - CW'(1);
                        if (pos_reg == CW'(1))
                        begin
                            state_next = depq_pkg::ST_WRITE;
                        end
                        else
                        begin
                            raddr = phys(head_reg, pos_reg - CW'(2));
                            state_next = depq_pkg::ST_CMP;
                        end
                    end
                    else
                    begin
                        state_next = depq_pkg::ST_WRITE;
                    end
                end
                else
                begin
                    res_next   = rdata[31:0];
                    count_next = count_reg - CW'(1);
                    if (kind_reg == depq_pkg::KIND_REM_LO)
                    begin
                        head_next = (head_reg == LAST) ? '0 : head_reg + AW'(1);
                    end
                    state_next = depq_pkg::ST_OUT;
                end
            end
            depq_pkg::ST_CMP:
            begin
                state_next = depq_pkg::ST_RD;
            end
            depq_pkg::ST_WRITE:
            begin
                we = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = depq_pkg::ST_OUT;
            end
            depq_pkg::ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    state_next = depq_pkg::ST_IDLE;
                end
            end
            default: state_next = depq_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for the double-ended priority queue: random and directed words vs. a predictor.
`default_nettype none
module tb_top;
    localparam int DEPTH = 256;
    localparam int CYCLE_LIMIT = 5000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] prio;
        logic [31:0] pay;
    } req_t;

    typedef struct packed {
        logic [31:0] pay;
        logic [1:0]  stat;
    } resp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic signed [31:0] priority_req;
    logic signed [31:0] payload;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] removed_payload;
    logic [1:0]  status;

    double_ended_priority_queue dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .priority_req(priority_req), .payload(payload),
        .out_valid(out_valid), .out_ready(out_ready),
        .removed_payload(removed_payload), .status(status)
    );

    // predictor state: sorted store, index 0 lowest priority
    logic [31:0] sorted_prio [DEPTH];
    logic [31:0] sorted_pay [DEPTH];
    int          held;

    req_t  pending_words [$];
    resp_t expected_results [$];
    int    errors;
    int    cycles;
    int    accepted;
    int    checked;
    bit    hold_off;
    int    full_hits;
    int    empty_hits;
    logic  in_ready_q;
    bit    pause_req;

    // compute the result of one request and update the store
    function automatic resp_t predict_queue(req_t r);
        resp_t res;
        int pos;
        int i;
        res.pay = '0;
        res.stat = depq_pkg::STAT_OK;
        case (depq_pkg::kind_t'(r.kind))
            depq_pkg::KIND_INSERT:
            begin
                if (held >= DEPTH)
                begin
                    res.stat = depq_pkg::STAT_FULL;
                end
                else
                begin
                    pos = held;
                    while (pos > 0 && $signed(sorted_prio[pos-1]) > $signed(r.prio))
                    begin
                        sorted_prio[pos] = sorted_prio[pos-1];
                        sorted_pay[pos] = sorted_pay[pos-1];
                        pos--;
                    end
                    sorted_prio[pos] = r.prio;
                    sorted_pay[pos] = r.pay;
                    held++;
                end
            end
            depq_pkg::KIND_REM_HI:
            begin
                if (held == 0)
                begin
                    res.stat = depq_pkg::STAT_EMPTY;
                end
                else
                begin
                    held--;
                    res.pay = sorted_pay[held];
                end
            end
            depq_pkg::KIND_REM_LO:
            begin
                if (held == 0)
                begin
                    res.stat = depq_pkg::STAT_EMPTY;
                end
                else
                begin
                    res.pay = sorted_pay[0];
                    for (i = 1; i < held; i++)
                    begin
                        sorted_prio[i-1] = sorted_prio[i];
                        sorted_pay[i-1] = sorted_pay[i];
                    end
                    held--;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic req_t make_word(depq_pkg::kind_t k, logic [31:0] p, logic [31:0] d);
        req_t r;
        r.kind = k;
        r.prio = p;
        r.pay = d;
        return r;
    endfunction

    // short gap mostly, long now and then
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver
    int in_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= '0;
            priority_req <= '0;
            payload <= '0;
            in_gap = 0;
        end
        else if (!(in_valid && !in_ready_q))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0 && !pause_req)
            begin
                in_valid <= 1'b1;
                kind <= pending_words[0].kind;
                priority_req <= pending_words[0].prio;
                payload <= pending_words[0].pay;
                void'(pending_words.pop_front());
                in_gap = pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // acceptance sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ready_q <= 1'b0;
        end
        else
        begin
            in_ready_q <= in_valid && in_ready ? 1'b1 : 1'b0;
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_queue(
                    make_word(depq_pkg::kind_t'(kind), priority_req, payload)));
                accepted++;
            end
        end
    end

    // receiver with random stalls and one long hold-off
    int out_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else if (hold_off)
        begin
            out_ready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            out_gap = pick_gap();
        end
    end

    // monitor
    resp_t want;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: payload %0d status %0d",
                    removed_payload, status);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                checked++;
                if (want.stat == depq_pkg::STAT_FULL)
                    full_hits++;
                if (want.stat == depq_pkg::STAT_EMPTY)
                    empty_hits++;
                if (removed_payload !== want.pay)
                begin
                    $error("removed_payload expected %0d actual %0d",
                        $signed(want.pay), removed_payload);
                    errors++;
                end
                if (status !== want.stat)
                begin
                    $error("status expected %0d actual %0d", want.stat, status);
                    errors++;
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("double_ended_priority_queue: mismatch");
            $finish;
        end
    end

    function automatic logic [31:0] rand_prio(int mode);
        case (mode)
            0: return $urandom_range(0, 7);
            1: return $urandom();
            default: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    // stimulus
    int i;
    int j;
    int n;
    int roll;
    int ins_bias;
    initial
    begin
        errors = 0;
        cycles = 0;
        accepted = 0;
        checked = 0;
        held = 0;
        hold_off = 1'b0;
        pause_req = 1'b0;
        full_hits = 0;
        empty_hits = 0;

        // directed: empty removals, extremes, ties, nop
        pending_words.push_back(make_word(depq_pkg::KIND_REM_HI, 32'h0, 32'h0));
        pending_words.push_back(make_word(depq_pkg::KIND_REM_LO, 32'hffff_ffff, 32'hffff_ffff));
        pending_words.push_back(make_word(depq_pkg::KIND_INSERT, 32'h8000_0000, 32'h8000_0000));
        pending_words.push_back(make_word(depq_pkg::KIND_INSERT, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_words.push_back(make_word(depq_pkg::KIND_INSERT, 32'h0000_0005, 32'h0000_0001));
        pending_words.push_back(make_word(depq_pkg::KIND_INSERT, 32'h0000_0005, 32'h0000_0002));
        pending_words.push_back(make_word(depq_pkg::KIND_INSERT, 32'h0000_0005, 32'hffff_ffff));
        pending_words.push_back(make_word(depq_pkg::KIND_INSERT, 32'hffff_ffff, 32'h5555_5555));
        pending_words.push_back(make_word(depq_pkg::KIND_NOP, 32'haaaa_aaaa, 32'h5555_5555));
        pending_words.push_back(make_word(depq_pkg::KIND_REM_HI, 32'h0, 32'h0));
        pending_words.push_back(make_word(depq_pkg::KIND_REM_LO, 32'h0, 32'h0));
        pending_words.push_back(make_word(depq_pkg::KIND_REM_HI, 32'h0, 32'h0));
        pending_words.push_back(make_word(depq_pkg::KIND_REM_LO, 32'h0, 32'h0));
        pending_words.push_back(make_word(depq_pkg::KIND_REM_HI, 32'h0, 32'h0));
        pending_words.push_back(make_word(depq_pkg::KIND_REM_LO, 32'h0, 32'h0));
        pending_words.push_back(make_word(depq_pkg::KIND_REM_LO, 32'h0, 32'h0));
        @(negedge clk);
        while (!rst_n)
            @(negedge clk);

        // fill past capacity, then drain with full-ahead stalls
        for (i = 0; i < DEPTH + 4; i++)
            pending_words.push_back(make_word(depq_pkg::KIND_INSERT,
                rand_prio(i % 3), $urandom()));
        for (i = 0; i < DEPTH + 2; i++)
            pending_words.push_back(make_word(($urandom_range(0, 1) != 0) ?
                depq_pkg::KIND_REM_HI : depq_pkg::KIND_REM_LO, $urandom(), $urandom()));

        // receiver holds off while the sender keeps offering
        repeat (20) @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;

        // sender waits until every result has come
        wait_drained();
        pause_req = 1'b1;
        repeat (5) @(posedge clk);
        pause_req = 1'b0;

        // random phases with shifting insert bias
        for (n = 0; n < 12; n++)
        begin
            ins_bias = (n % 3 == 0) ? 80 : ((n % 3 == 1) ? 50 : 25);
            for (j = 0; j < 90; j++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < ins_bias)
                    pending_words.push_back(make_word(depq_pkg::KIND_INSERT,
                        rand_prio($urandom_range(0, 2)), $urandom()));
                else if (roll < 97)
                    pending_words.push_back(make_word(($urandom_range(0, 1) != 0) ?
                        depq_pkg::KIND_REM_HI : depq_pkg::KIND_REM_LO,
                        $urandom(), $urandom()));
                else
                    pending_words.push_back(make_word(depq_pkg::KIND_NOP,
                        $urandom(), $urandom()));
            end
            wait_drained();
        end

        wait_drained();
        repeat (DEPTH + 20) @(posedge clk);

        $display("Run checked %0d results from %0d words; %0d full and %0d empty rejections.",
            checked, accepted, full_hits, empty_hits);
        if (errors == 0 && expected_results.size() == 0)
            $display("double_ended_priority_queue: match");
        else
            $display("double_ended_priority_queue: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
